// ----- src/assert_macros.svh -----
// Assertion macros shared by the projection core RTL.
// Depends on a clk and an active-low rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define WSP_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsp assertion failed");
`define WSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsp assertion failed");
`else
`define WSP_ASSERT(lbl, ante, cons)
`define WSP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- src/wsp_pkg.sv -----
// Types, constants, divider step function and saturation function for the projection core.
// No dependencies.
package wsp_pkg;

    localparam int COORD_W    = 32;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int FRAC_W     = 16;
    localparam int CLIP_W     = SUM_W - FRAC_W;
    localparam int MAG_W      = CLIP_W;
    localparam int QUO_W      = 40;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = QUO_W / DIV_STEPS;
    localparam int SIZE_W     = 15;
    localparam int NDC_W      = QUO_W + 2;
    localparam int VP_W       = NDC_W + 1;
    localparam int VPP_W      = VP_W + SIZE_W + 1;
    localparam int PIPE_LAT   = DIV_STAGES + 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int W_MIN_Q16  = 655;
    localparam int ONE_Q16    = 65536;

    localparam logic [CFG_IDX_W-1:0] CFG_X_A    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_B    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_A    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_B    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_W_A    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_W_B    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd7;

    localparam logic [SIZE_W-1:0] WIDTH_RST  = 15'd1920;
    localparam logic [SIZE_W-1:0] HEIGHT_RST = 15'd1080;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic                      visible;
        logic signed [COORD_W-1:0] screen_x;
        logic signed [COORD_W-1:0] screen_y;
    } screen_t;

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [QUO_W-1:0] num;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             cap;
    } div_lane_t;

    function automatic div_lane_t div_step(input div_lane_t lane, input logic [MAG_W-1:0] den);
        logic [MAG_W:0] trial;
        div_lane_t      res;
        res = lane;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            trial   = {res.rem, res.num[QUO_W-1]};
            res.num = {res.num[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, den})
            begin
                trial   = trial - {1'b0, den};
                res.quo = {res.quo[QUO_W-2:0], 1'b1};
            end
            else
            begin
                res.quo = {res.quo[QUO_W-2:0], 1'b0};
            end
            res.rem = trial[MAG_W-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [VPP_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if ((&v[VPP_W-1:COORD_W-1]) || !(|v[VPP_W-1:COORD_W-1]))
            r = v[COORD_W-1:0];
        else if (v[VPP_W-1])
            r = {1'b1, {(COORD_W-1){1'b0}}};
        else
            r = {1'b0, {(COORD_W-1){1'b1}}};
        return r;
    endfunction

endpackage

// ----- src/world_to_screen_projection_core.sv -----
// World-to-screen projection core: top level with config registers and valid pipeline.
// Depends on wsp_pkg, wsp_clip, wsp_div, wsp_view and assert_macros.svh.
//
// Takes one point beat per cycle unless the output stalls, and returns one screen beat
// per point, in order. The pipeline is 25 register stages deep, most of them in the
// 20-stage divider that resolves two quotient bits per stage for x/w and y/w in parallel.
// When the output beat is not taken the whole pipeline holds and point_ready drops.
// Configuration writes are always accepted and take effect at once; issue them only
// while no point is in flight.
`include "assert_macros.svh"
module world_to_screen_projection_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              point_valid,
    output logic                              point_ready,
    input  wsp_pkg::point_t                   point,
    output logic                              screen_valid,
    input  logic                              screen_ready,
    output wsp_pkg::screen_t                  screen,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wsp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wsp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [wsp_pkg::CFG_DATA_W-1:0] xa_reg, xb_reg, ya_reg, yb_reg, wa_reg, wb_reg;
    logic [wsp_pkg::SIZE_W-1:0]     width_reg, height_reg;
    logic [wsp_pkg::PIPE_LAT-1:0]   valid_reg, valid_next;
    logic                           en;

    logic signed [wsp_pkg::CLIP_W-1:0] clip_x, clip_y, clip_w;
    wsp_pkg::div_lane_t                res_x, res_y;
    logic                              vis;

    assign cfg_ready    = 1'b1;
    assign en           = !valid_reg[wsp_pkg::PIPE_LAT-1] || screen_ready;
    assign point_ready  = en;
    assign screen_valid = valid_reg[wsp_pkg::PIPE_LAT-1];
    assign valid_next   = {valid_reg[wsp_pkg::PIPE_LAT-2:0], point_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xa_reg     <= '0;
            xb_reg     <= '0;
            ya_reg     <= '0;
            yb_reg     <= '0;
            wa_reg     <= '0;
            wb_reg     <= '0;
            width_reg  <= wsp_pkg::WIDTH_RST;
            height_reg <= wsp_pkg::HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                wsp_pkg::CFG_X_A:    xa_reg     <= cfg_data;
                wsp_pkg::CFG_X_B:    xb_reg     <= cfg_data;
                wsp_pkg::CFG_Y_A:    ya_reg     <= cfg_data;
                wsp_pkg::CFG_Y_B:    yb_reg     <= cfg_data;
                wsp_pkg::CFG_W_A:    wa_reg     <= cfg_data;
                wsp_pkg::CFG_W_B:    wb_reg     <= cfg_data;
                wsp_pkg::CFG_WIDTH:  width_reg  <= cfg_data[wsp_pkg::SIZE_W-1:0];
                wsp_pkg::CFG_HEIGHT: height_reg <= cfg_data[wsp_pkg::SIZE_W-1:0];
                default:             width_reg  <= width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    wsp_clip u_clip_x (.clk(clk), .en(en), .point(point), .pair_a(xa_reg), .pair_b(xb_reg),
                       .clip(clip_x));
    wsp_clip u_clip_y (.clk(clk), .en(en), .point(point), .pair_a(ya_reg), .pair_b(yb_reg),
                       .clip(clip_y));
    wsp_clip u_clip_w (.clk(clk), .en(en), .point(point), .pair_a(wa_reg), .pair_b(wb_reg),
                       .clip(clip_w));

    wsp_div u_div (
        .clk(clk), .en(en), .clip_x(clip_x), .clip_y(clip_y), .clip_w(clip_w),
        .res_x(res_x), .res_y(res_y), .visible(vis)
    );

    wsp_view u_view (
        .clk(clk), .en(en), .res_x(res_x), .res_y(res_y), .visible(vis),
        .width(width_reg), .height(height_reg), .screen(screen)
    );

    `WSP_ASSERT_NEXT(a_accept_enters, point_valid && point_ready, valid_reg[0])
    `WSP_ASSERT(a_hidden_zero, screen_valid && !screen.visible, screen.screen_x == 0 && screen.screen_y == 0)
    `WSP_ASSERT_NEXT(a_stall_holds, !point_ready, $stable(valid_reg))

endmodule

// ----- src/wsp_clip.sv -----
// One clip coordinate: three products, then floored sum plus constant term.
// Depends on wsp_pkg.
module wsp_clip (
    input  logic                              clk,
    input  logic                              en,
    input  wsp_pkg::point_t                   point,
    input  logic [wsp_pkg::CFG_DATA_W-1:0]    pair_a,
    input  logic [wsp_pkg::CFG_DATA_W-1:0]    pair_b,
    output logic signed [wsp_pkg::CLIP_W-1:0] clip
);

    logic signed [wsp_pkg::PROD_W-1:0] p0_reg, p1_reg, p2_reg;
    logic signed [wsp_pkg::PROD_W-1:0] p0_next, p1_next, p2_next;
    logic signed [wsp_pkg::SUM_W-1:0]  sum;
    logic signed [wsp_pkg::CLIP_W-1:0] clip_reg, clip_next;

    assign p0_next = $signed(pair_a[31:0])  * point.point_x;
    assign p1_next = $signed(pair_a[63:32]) * point.point_y;
    assign p2_next = $signed(pair_b[31:0])  * point.point_z;

    assign sum = wsp_pkg::SUM_W'(p0_reg) + wsp_pkg::SUM_W'(p1_reg) + wsp_pkg::SUM_W'(p2_reg);
    assign clip_next = $signed(sum[wsp_pkg::SUM_W-1:wsp_pkg::FRAC_W])
                     + wsp_pkg::CLIP_W'($signed(pair_b[63:32]));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg   <= p0_next;
            p1_reg   <= p1_next;
            p2_reg   <= p2_next;
            clip_reg <= clip_next;
        end
    end

    assign clip = clip_reg;

endmodule

// ----- src/wsp_div.sv -----
// Pipelined restoring divider for x/w and y/w, two quotient bits a stage.
// Depends on wsp_pkg.
module wsp_div (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [wsp_pkg::CLIP_W-1:0] clip_x,
    input  logic signed [wsp_pkg::CLIP_W-1:0] clip_y,
    input  logic signed [wsp_pkg::CLIP_W-1:0] clip_w,
    output wsp_pkg::div_lane_t                res_x,
    output wsp_pkg::div_lane_t                res_y,
    output logic                              visible
);

    localparam int SH = wsp_pkg::QUO_W - wsp_pkg::FRAC_W;

    wsp_pkg::div_lane_t        lx_reg [wsp_pkg::DIV_STAGES+1];
    wsp_pkg::div_lane_t        ly_reg [wsp_pkg::DIV_STAGES+1];
    logic [wsp_pkg::MAG_W-1:0] den_reg [wsp_pkg::DIV_STAGES+1];
    logic                      vis_reg [wsp_pkg::DIV_STAGES+1];

    wsp_pkg::div_lane_t        lx_next, ly_next;
    logic [wsp_pkg::MAG_W-1:0] den_next, mag_x, mag_y;
    logic                      vis_next;

    assign mag_x = wsp_pkg::MAG_W'(clip_x[wsp_pkg::CLIP_W-1] ? -clip_x : clip_x);
    assign mag_y = wsp_pkg::MAG_W'(clip_y[wsp_pkg::CLIP_W-1] ? -clip_y : clip_y);
    assign den_next = wsp_pkg::MAG_W'(clip_w);
    assign vis_next = clip_w >= $signed(wsp_pkg::CLIP_W'(wsp_pkg::W_MIN_Q16));

    always_comb
    begin
        lx_next.rem = wsp_pkg::MAG_W'(mag_x[wsp_pkg::MAG_W-1:SH]);
        lx_next.num = {mag_x[SH-1:0], {wsp_pkg::FRAC_W{1'b0}}};
        lx_next.quo = '0;
        lx_next.neg = clip_x[wsp_pkg::CLIP_W-1];
        lx_next.cap = wsp_pkg::MAG_W'(mag_x[wsp_pkg::MAG_W-1:SH]) >= den_next;
        ly_next.rem = wsp_pkg::MAG_W'(mag_y[wsp_pkg::MAG_W-1:SH]);
        ly_next.num = {mag_y[SH-1:0], {wsp_pkg::FRAC_W{1'b0}}};
        ly_next.quo = '0;
        ly_next.neg = clip_y[wsp_pkg::CLIP_W-1];
        ly_next.cap = wsp_pkg::MAG_W'(mag_y[wsp_pkg::MAG_W-1:SH]) >= den_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lx_reg[0]  <= lx_next;
            ly_reg[0]  <= ly_next;
            den_reg[0] <= den_next;
            vis_reg[0] <= vis_next;
        end
    end

    for (genvar s = 0; s < wsp_pkg::DIV_STAGES; s++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lx_reg[s+1]  <= wsp_pkg::div_step(lx_reg[s], den_reg[s]);
                ly_reg[s+1]  <= wsp_pkg::div_step(ly_reg[s], den_reg[s]);
                den_reg[s+1] <= den_reg[s];
                vis_reg[s+1] <= vis_reg[s];
            end
        end
    end

    assign res_x   = lx_reg[wsp_pkg::DIV_STAGES];
    assign res_y   = ly_reg[wsp_pkg::DIV_STAGES];
    assign visible = vis_reg[wsp_pkg::DIV_STAGES];

endmodule

// ----- src/wsp_view.sv -----
// Viewport mapping: scale by screen size, halve, saturate, blank if hidden.
// Depends on wsp_pkg.
module wsp_view (
    input  logic                        clk,
    input  logic                        en,
    input  wsp_pkg::div_lane_t          res_x,
    input  wsp_pkg::div_lane_t          res_y,
    input  logic                        visible,
    input  logic [wsp_pkg::SIZE_W-1:0]  width,
    input  logic [wsp_pkg::SIZE_W-1:0]  height,
    output wsp_pkg::screen_t            screen
);

    localparam logic [wsp_pkg::NDC_W-1:0] NDC_CAP = wsp_pkg::NDC_W'(1) << wsp_pkg::QUO_W;
    localparam logic signed [wsp_pkg::VP_W-1:0] ONE = wsp_pkg::VP_W'(wsp_pkg::ONE_Q16);

    logic [wsp_pkg::NDC_W-1:0]         mx, my, nx, ny;
    logic signed [wsp_pkg::VP_W-1:0]   vx, vy;
    logic signed [wsp_pkg::VPP_W-1:0]  px_reg, px_next, py_reg, py_next;
    logic signed [wsp_pkg::VPP_W-1:0]  hx, hy;
    logic                              vis_reg;
    wsp_pkg::screen_t                  out_reg, out_next;

    assign mx = res_x.cap ? NDC_CAP : wsp_pkg::NDC_W'(res_x.quo);
    assign my = res_y.cap ? NDC_CAP : wsp_pkg::NDC_W'(res_y.quo);
    assign nx = res_x.neg ? -mx : mx;
    assign ny = res_y.neg ? -my : my;
    assign vx = ONE + $signed({nx[wsp_pkg::NDC_W-1], nx});
    assign vy = ONE - $signed({ny[wsp_pkg::NDC_W-1], ny});
    assign px_next = $signed({1'b0, width})  * vx;
    assign py_next = $signed({1'b0, height}) * vy;

    assign hx = px_reg >>> 1;
    assign hy = py_reg >>> 1;

    always_comb
    begin
        out_next.visible  = vis_reg;
        out_next.screen_x = vis_reg ? wsp_pkg::sat32(hx) : '0;
        out_next.screen_y = vis_reg ? wsp_pkg::sat32(hy) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg  <= px_next;
            py_reg  <= py_next;
            vis_reg <= visible;
            out_reg <= out_next;
        end
    end

    assign screen = out_reg;

endmodule
